@@ rtl/core/fslr_pkg.sv @@
// fslr_pkg: shared types, constants and rounding helpers for the face state
// reconstruction datapath. No dependencies.
package fslr_pkg;

   // value format, signed fixed point (the fraction point never moves)
   localparam int VALUE_WIDTH = 32;
   // internal width: room for a three-term sum and slope doubling without overflow
   localparam int WIDE_WIDTH = VALUE_WIDTH + 4;

   // divide-by-three by reciprocal multiply: exact for dividends below 2**DIV_IN_WIDTH
   localparam int DIV_IN_WIDTH = VALUE_WIDTH + 2;
   localparam int DIV_SHIFT = VALUE_WIDTH + 3;
   localparam int DIV_PROD_WIDTH = DIV_IN_WIDTH + DIV_SHIFT;
   localparam logic [DIV_SHIFT:0] DIV_POW = {1'b1, {DIV_SHIFT{1'b0}}};
   localparam logic [DIV_SHIFT-1:0] THIRD_MUL =
      DIV_SHIFT'((DIV_POW + (DIV_SHIFT + 1)'(2)) / (DIV_SHIFT + 1)'(3));

   localparam logic signed [WIDE_WIDTH-1:0] VALUE_MAX =
      {{(WIDE_WIDTH - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
   localparam logic signed [WIDE_WIDTH-1:0] VALUE_MIN =
      {{(WIDE_WIDTH - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

   typedef enum logic [2:0] {
      MODE_FIRST        = 3'd0,
      MODE_SECOND       = 3'd1,
      MODE_FACE_SECOND  = 3'd2,
      MODE_LIMITED      = 3'd3,
      MODE_FACE_LIMITED = 3'd4
   } scheme_type;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [WIDE_WIDTH-1:0] wide_type;

   typedef struct packed {
      value_type vertex_left;
      value_type cell_left;
      value_type cell_right;
      value_type vertex_right;
      value_type face_vertex_a;
      value_type face_vertex_b;
      value_type face_vertex_c;
      logic      interior_face;
   } req_payload_type;

   typedef struct packed {
      value_type left_value;
      value_type right_value;
      logic      right_valid;
   } rsp_payload_type;

   // registered between the front stage and the side evaluation
   typedef struct packed {
      wide_type vertex_left;
      wide_type cell_left;
      wide_type cell_right;
      wide_type vertex_right;
      wide_type face_average;
      wide_type third_left;
      wide_type third_right;
      logic     interior_face;
   } stage_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       interior_face;
      wide_type   vertex;
      wide_type   centre;
      wide_type   neighbour;
      wide_type   face_average;
      wide_type   third_slope;
   } side_in_type;

   function automatic wide_type widen(value_type x);
      return WIDE_WIDTH'(x);
   endfunction

   function automatic logic [WIDE_WIDTH-1:0] magnitude(wide_type x);
      wide_type neg_x;
      neg_x = -x;
      return x[WIDE_WIDTH-1] ? $unsigned(neg_x) : $unsigned(x);
   endfunction

   function automatic wide_type apply_sign(logic [WIDE_WIDTH-1:0] m, logic neg);
      wide_type s;
      s = $signed(m);
      return neg ? -s : s;
   endfunction

   // round to nearest, ties away from zero
   function automatic wide_type half_round(wide_type x);
      logic [WIDE_WIDTH-1:0] m;
      m = magnitude(x);
      return apply_sign((m + WIDE_WIDTH'(1)) >> 1, x[WIDE_WIDTH-1]);
   endfunction

   function automatic wide_type quarter_round(wide_type x);
      logic [WIDE_WIDTH-1:0] m;
      m = magnitude(x);
      return apply_sign((m + WIDE_WIDTH'(2)) >> 2, x[WIDE_WIDTH-1]);
   endfunction

   // round to nearest via constant reciprocal, no divider
   function automatic wide_type third_round(wide_type x);
      logic [WIDE_WIDTH-1:0]     m;
      logic [DIV_IN_WIDTH-1:0]   xp;
      logic [DIV_PROD_WIDTH-1:0] prod;
      m = magnitude(x);
      xp = DIV_IN_WIDTH'(m + WIDE_WIDTH'(1));
      prod = DIV_PROD_WIDTH'(xp) * DIV_PROD_WIDTH'(THIRD_MUL);
      return apply_sign(WIDE_WIDTH'(prod[DIV_PROD_WIDTH-1:DIV_SHIFT]), x[WIDE_WIDTH-1]);
   endfunction

   function automatic logic same_sign(wide_type a, wide_type b);
      return ((a > 0) && (b > 0)) || ((a < 0) && (b < 0));
   endfunction

   function automatic value_type saturate(wide_type x);
      if (x > VALUE_MAX) begin
         return VALUE_WIDTH'(VALUE_MAX);
      end else if (x < VALUE_MIN) begin
         return VALUE_WIDTH'(VALUE_MIN);
      end
      return VALUE_WIDTH'(x);
   endfunction

endpackage

@@ rtl/core/fslr_prep.sv @@
// fslr_prep: front stage, widens the operands, forms the face average and
// the rounded one-third slopes of both cells. Depends on fslr_pkg.
module fslr_prep (
   input  fslr_pkg::req_payload_type item,
   output fslr_pkg::stage_type       stage
);
   import fslr_pkg::*;

   wide_type face_sum;
   wide_type diff_left;
   wide_type diff_right;

   always_comb begin
      face_sum = widen(item.face_vertex_a) + widen(item.face_vertex_b)
                 + widen(item.face_vertex_c);
      diff_left = widen(item.cell_left) - widen(item.vertex_left);
      diff_right = widen(item.cell_right) - widen(item.vertex_right);

      stage.vertex_left = widen(item.vertex_left);
      stage.cell_left = widen(item.cell_left);
      stage.cell_right = widen(item.cell_right);
      stage.vertex_right = widen(item.vertex_right);
      stage.face_average = third_round(face_sum);
      stage.third_left = third_round(diff_left);
      stage.third_right = third_round(diff_right);
      stage.interior_face = item.interior_face;
   end

endmodule

@@ rtl/core/fslr_side.sv @@
// fslr_side: reconstructed state of one side of the face for the selected
// scheme, with the divider-free limiter and output saturation. Depends on fslr_pkg.
module fslr_side (
   input  fslr_pkg::side_in_type side,
   output fslr_pkg::value_type   value
);
   import fslr_pkg::*;

   wide_type diff_cv;
   wide_type diff_av;
   wide_type diff_ac;
   wide_type diff_nc;
   wide_type slope_half;
   wide_type slope_quarter;
   wide_type result;
   logic     plain_ok;
   logic     plain_small;
   logic     face_ok;
   logic     face_small;
   logic     bnd_ok;

   always_comb begin
      diff_cv = side.centre - side.vertex;
      diff_av = side.face_average - side.vertex;
      diff_ac = side.face_average - side.centre;
      diff_nc = side.neighbour - side.centre;
      slope_half = half_round(diff_nc);
      slope_quarter = quarter_round(diff_av);

      // ratio below two, tested as |dC| < 2|dP|
      plain_ok = same_sign(side.third_slope, slope_half);
      plain_small = {2'b00, magnitude(side.third_slope)}
                    < {1'b0, magnitude(slope_half), 1'b0};
      face_ok = same_sign(diff_cv, diff_nc) && same_sign(diff_av, diff_nc);
      face_small = {2'b00, magnitude(diff_av)} < {magnitude(diff_nc), 2'b00};
      // one-sided test on a boundary face
      bnd_ok = same_sign(diff_ac, diff_cv);

      result = side.centre;
      unique case (side.mode)
         MODE_SECOND: begin
            result = side.centre + side.third_slope;
         end
         MODE_FACE_SECOND: begin
            result = side.centre + slope_quarter;
         end
         MODE_LIMITED: begin
            if (side.interior_face) begin
               if (plain_ok) begin
                  result = plain_small ? side.centre + side.third_slope
                                       : side.centre + (slope_half <<< 1);
               end
            end else if (bnd_ok) begin
               result = side.centre + side.third_slope;
            end
         end
         MODE_FACE_LIMITED: begin
            if (side.interior_face) begin
               if (face_ok) begin
                  result = face_small ? side.centre + slope_quarter : side.neighbour;
               end
            end else if (bnd_ok) begin
               result = side.centre + slope_quarter;
            end
         end
         default: begin
            result = side.centre;
         end
      endcase

      value = saturate(result);
   end

endmodule

@@ rtl/core/face_state_limited_reconstruction_unit.sv @@
// face_state_limited_reconstruction_unit: top level, pipeline control, scheme
// register and result register. Depends on fslr_pkg, fslr_prep and fslr_side.
//
// Per face and per scalar component this unit turns the gathered left and right
// cell averages, the values at the vertices opposite the face, the three face
// vertex values and an interior flag into left and right reconstructed states
// (signed fixed point, saturated). csr_write_data selects the scheme: first
// order, second order, face-average second order, limited or face-average
// limited; codes 5 to 7 behave as first order. Write it only while no
// transaction is in flight. A boundary face returns right_value zero with
// right_valid low. The datapath is three register stages deep: input register,
// a front stage (face average and the three divide-by-three reciprocal
// multiplies, the longest path), and the side evaluation feeding the result
// register. A taken request passes through the input, front-stage and result
// registers in turn before its response is presented, and one transaction is
// taken every cycle while the response side keeps up; each stage
// holds its contents when the next one is full, so back-pressure stalls the pipe
// without losing or repeating a transaction.
module face_state_limited_reconstruction_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  fslr_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output fslr_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [2:0]                csr_write_data
);
   import fslr_pkg::*;

   // scheme register, may hold undefined codes
   logic [2:0]      mode_ff;
   logic [2:0]      mode_in;

   // stage valid bits
   logic            in_valid_ff;
   logic            in_valid_in;
   logic            mid_valid_ff;
   logic            mid_valid_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;

   // stage payloads
   req_payload_type in_payload_ff;
   stage_type       mid_stage_ff;
   stage_type       mid_stage_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   // handshake helpers
   logic            req_take;
   logic            rsp_take;
   logic            out_free;
   logic            mid_free;
   logic            in_free;
   logic            in_move;
   logic            mid_move;

   side_in_type     left_side;
   side_in_type     right_side;
   value_type       left_result;
   value_type       right_result;

   // a stage can load when empty or when its contents leave this cycle
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      mid_move = mid_valid_ff && out_free;
      mid_free = !mid_valid_ff || out_free;
      in_move = in_valid_ff && mid_free;
      in_free = !in_valid_ff || mid_free;
      req_ready = in_free && !reset;
      req_take = req_valid && req_ready;
      rsp_take = rsp_valid_ff && rsp_ready;
   end

   always_comb begin
      mode_in = csr_write_enable ? csr_write_data : mode_ff;
      in_valid_in = req_take ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);
      mid_valid_in = in_move ? 1'b1 : (mid_move ? 1'b0 : mid_valid_ff);
      rsp_valid_in = mid_move ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_ff);
   end

   // front stage: average and one-third slopes
   fslr_prep u_prep (
      .item  (in_payload_ff),
      .stage (mid_stage_in)
   );

   // both sides share the face average, neighbours swap roles
   always_comb begin
      left_side.mode = mode_ff;
      left_side.interior_face = mid_stage_ff.interior_face;
      left_side.vertex = mid_stage_ff.vertex_left;
      left_side.centre = mid_stage_ff.cell_left;
      left_side.neighbour = mid_stage_ff.cell_right;
      left_side.face_average = mid_stage_ff.face_average;
      left_side.third_slope = mid_stage_ff.third_left;

      right_side.mode = mode_ff;
      right_side.interior_face = mid_stage_ff.interior_face;
      right_side.vertex = mid_stage_ff.vertex_right;
      right_side.centre = mid_stage_ff.cell_right;
      right_side.neighbour = mid_stage_ff.cell_left;
      right_side.face_average = mid_stage_ff.face_average;
      right_side.third_slope = mid_stage_ff.third_right;
   end

   fslr_side u_side_left (
      .side  (left_side),
      .value (left_result)
   );

   fslr_side u_side_right (
      .side  (right_side),
      .value (right_result)
   );

   // boundary face has no right state
   always_comb begin
      rsp_payload_in.left_value = left_result;
      rsp_payload_in.right_value = mid_stage_ff.interior_face ? right_result : '0;
      rsp_payload_in.right_valid = mid_stage_ff.interior_face;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FIRST;
         in_valid_ff <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         in_valid_ff <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, loaded on stage advance only
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_payload_ff <= req_payload;
      end
      if (in_move) begin
         mid_stage_ff <= mid_stage_in;
      end
      if (mid_move) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
